/* sv/lfpid_pkg.sv */
// shared constants, codes and types for the line follower pid steering block
// no dependencies; imported by lfpid_div and line_follower_pid_steering
`default_nettype none

package lfpid_pkg;

	// item geometry
	localparam int SENSOR_COUNT = 6;
	localparam int SAMPLE_W     = 8;
	localparam int DRIVE_W      = 9;
	localparam int WEIGHT_STEP  = 1000;
	localparam int EDGE_LEVEL   = 50;
	localparam int OFF_BOOST    = 20;

	// serial divider geometry
	localparam int DIV_W  = 22;
	localparam int DEN_W  = 15;
	localparam int CNT_W  = 5;
	localparam int POS_N  = 22;
	localparam int PERR_N = 13;
	localparam int IERR_N = 15;
	localparam int DERR_N = 14;

	// configuration port
	localparam int CFG_W = 15;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_TOLERANCE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_P_DIVISOR      = 3'd1;
	localparam logic [IDX_W-1:0] REG_I_DIVISOR      = 3'd2;
	localparam logic [IDX_W-1:0] REG_D_DIVISOR      = 3'd3;
	localparam logic [IDX_W-1:0] REG_LINE_CENTER    = 3'd4;
	localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_SPEED      = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPEED_RANGE    = 3'd7;

	// register reset values
	localparam logic [7:0]  RST_TOLERANCE      = 8'd30;
	localparam logic [6:0]  RST_P_DIVISOR      = 7'd14;
	localparam logic [14:0] RST_I_DIVISOR      = 15'd240;
	localparam logic [7:0]  RST_D_DIVISOR      = 8'd2;
	localparam logic [12:0] RST_LINE_CENTER    = 13'd2500;
	localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd30000;
	localparam logic [7:0]  RST_MIN_SPEED      = 8'd40;
	localparam logic [7:0]  RST_SPEED_RANGE    = 8'd100;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_GO,
		ST_DIV,
		ST_CLAMP,
		ST_SPLIT,
		ST_DONE
	} lfpid_state_t;

	// which quotient the shared divider is working on
	typedef enum logic [1:0] {
		OP_POS,
		OP_P,
		OP_I,
		OP_D
	} lfpid_op_t;

endpackage

`default_nettype wire

/* sv/line_follower_pid_steering.sv */
// line follower pid steering: centroid, pid terms, clamp and drive split
// beats are accepted only in idle, and none until the last result has left done
// off track, prep goes straight to done; on track, the shared serial divider
// runs 22 + 13 + 15 + 14 iterations (centroid, p, i, d terms) one bit per cycle
// a result waiting on out_stall holds the next item in its final state only
// reset: registers take their default values, pid state and edge memory clear
// depends on lfpid_pkg and lfpid_div
`default_nettype none

module line_follower_pid_steering (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          restart,
	input  wire logic [7:0]                    sample_1,
	input  wire logic [7:0]                    sample_2,
	input  wire logic [7:0]                    sample_3,
	input  wire logic [7:0]                    sample_4,
	input  wire logic [7:0]                    sample_5,
	input  wire logic [7:0]                    sample_6,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [8:0]                         left_drive,
	output logic [8:0]                         right_drive,
	output logic                               off_track,
	output logic                               edge_seen,
	output logic signed [8:0]                  correction,
	// configuration write port
	input  wire logic                          wr_en,
	input  wire logic [lfpid_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [lfpid_pkg::CFG_W-1:0]   wr_data
);
	import lfpid_pkg::*;

	// configuration registers
	logic [7:0]  tolerance_q;
	logic [6:0]  p_divisor_q;
	logic [14:0] i_divisor_q;
	logic [7:0]  d_divisor_q;
	logic [12:0] line_center_q;
	logic [14:0] integral_limit_q;
	logic [7:0]  min_speed_q;
	logic [7:0]  speed_range_q;

	// sequencer
	lfpid_state_t state_q, state_d;
	lfpid_op_t    op_q;
	logic         div_start;
	logic         accept;

	// item and pid state
	logic [SAMPLE_W-1:0] samp_q [SENSOR_COUNT];
	logic signed [13:0]  prev_err_q;
	logic signed [15:0]  integ_q;
	logic                last_edge_q;
	logic signed [13:0]  err_q;
	logic signed [14:0]  derr_q;
	logic signed [16:0]  acc_q;
	logic signed [8:0]   corr_q;

	// finished result
	logic [8:0]        res_left_q;
	logic [8:0]        res_right_q;
	logic              res_off_q;
	logic signed [8:0] res_corr_q;

	// output register
	logic              out_valid_q;
	logic [8:0]        left_q;
	logic [8:0]        right_q;
	logic              off_q;
	logic              edge_q;
	logic signed [8:0] corr_out_q;
	logic              out_free;

	// divider hookup
	logic [DIV_W-1:0] div_dividend;
	logic [DEN_W-1:0] div_divisor;
	logic [CNT_W-1:0] div_nbits;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	// combinational datapath
	logic [10:0]        sum_w;
	logic [11:0]        wcnt_w;
	logic [DIV_W-1:0]   wsum_w;
	logic               all_low_w;
	logic               off_w;
	logic               edge_w;
	logic [8:0]         boost_w;
	logic [6:0]         p_eff;
	logic [14:0]        i_eff;
	logic [7:0]         d_eff;
	logic [12:0]        err_mag;
	logic [14:0]        integ_mag;
	logic [13:0]        derr_mag;
	logic signed [13:0] err_w;
	logic signed [14:0] derr_w;
	logic signed [16:0] cand_w;
	logic signed [16:0] lim_w;
	logic signed [16:0] q_w;
	logic               q_neg;
	logic signed [16:0] term_w;
	logic signed [16:0] rng_w;
	logic signed [8:0]  clamp_w;
	logic signed [8:0]  half_corr;
	logic signed [9:0]  half_w;
	logic signed [9:0]  left_w;
	logic signed [9:0]  right_w;

	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q      <= RST_TOLERANCE;
			p_divisor_q      <= RST_P_DIVISOR;
			i_divisor_q      <= RST_I_DIVISOR;
			d_divisor_q      <= RST_D_DIVISOR;
			line_center_q    <= RST_LINE_CENTER;
			integral_limit_q <= RST_INTEGRAL_LIMIT;
			min_speed_q      <= RST_MIN_SPEED;
			speed_range_q    <= RST_SPEED_RANGE;
		end else if (wr_en) begin
			case (wr_index)
				REG_TOLERANCE:      tolerance_q      <= wr_data[7:0];
				REG_P_DIVISOR:      p_divisor_q      <= wr_data[6:0];
				REG_I_DIVISOR:      i_divisor_q      <= wr_data[14:0];
				REG_D_DIVISOR:      d_divisor_q      <= wr_data[7:0];
				REG_LINE_CENTER:    line_center_q    <= wr_data[12:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= wr_data[14:0];
				REG_MIN_SPEED:      min_speed_q      <= wr_data[7:0];
				REG_SPEED_RANGE:    speed_range_q    <= wr_data[7:0];
				default:            tolerance_q      <= tolerance_q;
			endcase
		end
	end

	// zero divisors act as one
	assign p_eff = (p_divisor_q == '0) ? 7'd1 : p_divisor_q;
	assign i_eff = (i_divisor_q == '0) ? 15'd1 : i_divisor_q;
	assign d_eff = (d_divisor_q == '0) ? 8'd1 : d_divisor_q;

	// sample sum, weighted sum, off-line test and edge memory
	always_comb begin
		sum_w     = '0;
		wcnt_w    = '0;
		all_low_w = 1'b1;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			sum_w  = sum_w + 11'(samp_q[i]);
			wcnt_w = wcnt_w + 12'(samp_q[i]) * 12'(i);
			if (samp_q[i] >= tolerance_q) begin
				all_low_w = 1'b0;
			end
		end
		wsum_w = DIV_W'(wcnt_w) * DIV_W'(WEIGHT_STEP);
		off_w  = all_low_w | (sum_w == '0);
		if (samp_q[0] > SAMPLE_W'(EDGE_LEVEL)) begin
			edge_w = 1'b0;
		end else if (samp_q[SENSOR_COUNT-1] > SAMPLE_W'(EDGE_LEVEL)) begin
			edge_w = 1'b1;
		end else begin
			edge_w = last_edge_q;
		end
		boost_w = 9'(min_speed_q) + 9'(OFF_BOOST);
	end

	// magnitudes handed to the divider
	always_comb begin
		err_mag   = 13'(err_q[13] ? -err_q : err_q);
		integ_mag = 15'(integ_q[15] ? -integ_q : integ_q);
		derr_mag  = 14'(derr_q[14] ? -derr_q : derr_q);
	end

	// divider operand select, dividend left aligned to the iteration count
	always_comb begin
		case (op_q)
			OP_POS: begin
				div_dividend = wsum_w;
				div_divisor  = DEN_W'(sum_w);
				div_nbits    = CNT_W'(POS_N);
			end
			OP_P: begin
				div_dividend = {err_mag, (DIV_W-PERR_N)'(0)};
				div_divisor  = DEN_W'(p_eff);
				div_nbits    = CNT_W'(PERR_N);
			end
			OP_I: begin
				div_dividend = {integ_mag, (DIV_W-IERR_N)'(0)};
				div_divisor  = i_eff;
				div_nbits    = CNT_W'(IERR_N);
			end
			OP_D: begin
				div_dividend = {derr_mag, (DIV_W-DERR_N)'(0)};
				div_divisor  = DEN_W'(d_eff);
				div_nbits    = CNT_W'(DERR_N);
			end
			default: begin
				div_dividend = wsum_w;
				div_divisor  = DEN_W'(sum_w);
				div_nbits    = CNT_W'(POS_N);
			end
		endcase
	end

	lfpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.done     (div_done),
		.quotient (div_quo)
	);

	// error, derivative and integral candidate from the centroid
	always_comb begin
		err_w  = $signed({1'b0, div_quo[12:0]}) - $signed({1'b0, line_center_q});
		derr_w = 15'(err_w) - 15'(prev_err_q);
		cand_w = 17'(integ_q) + 17'(err_w >>> 8);
		lim_w  = $signed({2'b00, integral_limit_q});
	end

	// signed term from the unsigned quotient
	always_comb begin
		q_w = $signed({1'b0, div_quo[15:0]});
		case (op_q)
			OP_P:    q_neg = err_q[13];
			OP_I:    q_neg = integ_q[15];
			OP_D:    q_neg = derr_q[14];
			default: q_neg = 1'b0;
		endcase
		term_w = q_neg ? -q_w : q_w;
	end

	// clamp and drive split, half of the correction rounds toward zero
	always_comb begin
		rng_w = $signed({9'b0, speed_range_q});
		if (acc_q > rng_w) begin
			clamp_w = 9'(rng_w);
		end else if (acc_q < -rng_w) begin
			clamp_w = 9'(-rng_w);
		end else begin
			clamp_w = 9'(acc_q);
		end
		half_corr = (corr_q + $signed({8'b0, corr_q[8]})) >>> 1;
		half_w    = $signed({2'b00, min_speed_q}) + $signed({3'b000, speed_range_q[7:1]});
		left_w    = half_w - 10'(half_corr);
		right_w   = half_w + 10'(half_corr);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (off_w) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (op_q == OP_D) ? ST_CLAMP : ST_GO;
				end
			end
			ST_CLAMP: state_d = ST_SPLIT;
			ST_SPLIT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pid state and edge memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			integ_q     <= '0;
			last_edge_q <= 1'b0;
		end else begin
			if (accept && restart) begin
				prev_err_q <= '0;
				integ_q    <= '0;
			end
			if (state_q == ST_PREP) begin
				last_edge_q <= edge_w;
			end
			if (state_q == ST_DIV && div_done && op_q == OP_POS) begin
				prev_err_q <= err_w;
				if (!(cand_w >= lim_w || cand_w <= -lim_w)) begin
					integ_q <= 16'(cand_w);
				end
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q[0] <= sample_1;
			samp_q[1] <= sample_2;
			samp_q[2] <= sample_3;
			samp_q[3] <= sample_4;
			samp_q[4] <= sample_5;
			samp_q[5] <= sample_6;
			op_q      <= OP_POS;
		end
		case (state_q)
			ST_PREP: begin
				res_off_q  <= off_w;
				res_corr_q <= '0;
				if (edge_w) begin
					res_left_q  <= 9'(min_speed_q);
					res_right_q <= boost_w;
				end else begin
					res_left_q  <= boost_w;
					res_right_q <= 9'(min_speed_q);
				end
			end
			ST_DIV: begin
				if (div_done) begin
					case (op_q)
						OP_POS: begin
							err_q  <= err_w;
							derr_q <= derr_w;
							op_q   <= OP_P;
						end
						OP_P: begin
							acc_q <= term_w;
							op_q  <= OP_I;
						end
						OP_I: begin
							acc_q <= acc_q + term_w;
							op_q  <= OP_D;
						end
						OP_D: acc_q <= acc_q + term_w;
						default: op_q <= OP_POS;
					endcase
				end
			end
			ST_CLAMP: corr_q <= clamp_w;
			ST_SPLIT: begin
				res_corr_q  <= corr_q;
				res_left_q  <= 9'(left_w);
				res_right_q <= 9'(right_w);
			end
			default: res_off_q <= res_off_q;
		endcase
	end

	// output register, free again once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			left_q     <= res_left_q;
			right_q    <= res_right_q;
			off_q      <= res_off_q;
			edge_q     <= last_edge_q;
			corr_out_q <= res_corr_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign off_track   = off_q;
	assign edge_seen   = edge_q;
	assign correction  = corr_out_q;

endmodule

`default_nettype wire

/* sv/lfpid_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on lfpid_pkg; dividend arrives left aligned, nbits sets the iteration count
`default_nettype none

module lfpid_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lfpid_pkg::DIV_W-1:0] dividend,
	input  wire logic [lfpid_pkg::DEN_W-1:0] divisor,
	input  wire logic [lfpid_pkg::CNT_W-1:0] nbits,
	output logic                             done,
	output logic [lfpid_pkg::DIV_W-1:0]      quotient
);
	import lfpid_pkg::*;

	logic [DEN_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             fits;

	// one trial subtract per cycle
	always_comb begin
		shifted = {rem_q[DEN_W-1:0], quo_q[DIV_W-1]};
		trial   = {1'b0, shifted} - {2'b00, divisor};
		fits    = ~trial[DEN_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= nbits;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? trial[DEN_W:0] : shifted;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* tb/tb_line_follower_pid_steering.sv */
// self-checking testbench for line_follower_pid_steering: directed table, then random track frames
// uses its own drive predictor and scoreboard; depends on lfpid_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_line_follower_pid_steering;
	import lfpid_pkg::*;

	// one input beat
	typedef struct {
		logic       rst;
		logic [7:0] smp [SENSOR_COUNT];
	} frame_t;

	// one output beat
	typedef struct packed {
		logic [8:0]        l_drv;
		logic [8:0]        r_drv;
		logic              off;
		logic              edge_right;
		logic signed [8:0] corr;
	} steer_t;

	// a full register set
	typedef struct {
		int tol;
		int pdiv;
		int idiv;
		int ddiv;
		int center;
		int ilim;
		int vmin;
		int spd;
	} tuning_t;

	typedef struct {
		int     tune;
		frame_t f;
		bit     typed;
		steer_t want;
	} script_row_t;

	localparam int NO_TUNE       = -1;
	localparam int TUNE_RESET    = 0;
	localparam int TUNE_ZERO_DIV = 1;
	localparam int TUNE_HIGH     = 2;
	localparam int TUNE_LOW      = 3;
	localparam int TUNE_MID      = 4;
	localparam int N_ROWS        = 23;
	localparam int HOLD_CYCLES   = 400;

	tuning_t tunings [5] = '{
		'{RST_TOLERANCE, RST_P_DIVISOR, RST_I_DIVISOR, RST_D_DIVISOR, RST_LINE_CENTER,
			RST_INTEGRAL_LIMIT, RST_MIN_SPEED, RST_SPEED_RANGE},
		'{30, 0, 0, 0, 2500, 20, 40, 255},
		'{255, 127, 32767, 255, 8191, 32767, 255, 255},
		'{0, 1, 1, 1, 0, 0, 0, 0},
		'{60, 5, 64, 3, 5000, 2000, 100, 254}
	};

	// directed beats; typed rows carry their drives, the rest go through the predictor
	script_row_t script [N_ROWS] = '{
		'{NO_TUNE, '{1'b0, '{0, 0, 0, 0, 0, 0}}, 1'b1, '{9'd60, 9'd40, 1'b1, 1'b0, 9'sd0}},
		'{NO_TUNE, '{1'b1, '{100, 100, 100, 100, 100, 100}}, 1'b1,
			'{9'd90, 9'd90, 1'b0, 1'b0, 9'sd0}},
		'{NO_TUNE, '{1'b1, '{0, 0, 0, 0, 0, 255}}, 1'b1, '{9'd40, 9'd140, 1'b0, 1'b1, 9'sd100}},
		'{NO_TUNE, '{1'b0, '{20, 20, 20, 20, 20, 20}}, 1'b1,
			'{9'd40, 9'd60, 1'b1, 1'b1, 9'sd0}},
		'{NO_TUNE, '{1'b0, '{0, 0, 0, 0, 0, 0}}, 1'b1, '{9'd40, 9'd60, 1'b1, 1'b1, 9'sd0}},
		'{NO_TUNE, '{1'b1, '{255, 0, 0, 0, 0, 0}}, 1'b1, '{9'd140, 9'd40, 1'b0, 1'b0, -9'sd100}},
		'{NO_TUNE, '{1'b0, '{255, 255, 255, 255, 255, 255}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{30, 30, 30, 30, 30, 30}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{29, 29, 29, 29, 29, 29}}, 1'b1, '{9'd60, 9'd40, 1'b1, 1'b0, 9'sd0}},
		'{NO_TUNE, '{1'b0, '{51, 0, 0, 0, 0, 51}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{50, 0, 0, 0, 0, 51}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{50, 0, 0, 0, 0, 50}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hBF}}, 1'b0, '0},
		'{TUNE_ZERO_DIV, '{1'b1, '{0, 0, 0, 0, 0, 255}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{0, 0, 0, 0, 0, 255}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{0, 0, 0, 0, 0, 255}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{255, 0, 0, 0, 0, 0}}, 1'b0, '0},
		'{TUNE_LOW, '{1'b0, '{0, 0, 0, 0, 0, 0}}, 1'b1, '{9'd20, 9'd0, 1'b1, 1'b0, 9'sd0}},
		'{NO_TUNE, '{1'b0, '{0, 0, 1, 0, 0, 0}}, 1'b1, '{9'd0, 9'd0, 1'b0, 1'b0, 9'sd0}},
		'{TUNE_HIGH, '{1'b1, '{254, 254, 254, 254, 254, 254}}, 1'b1,
			'{9'd275, 9'd255, 1'b1, 1'b0, 9'sd0}},
		'{NO_TUNE, '{1'b1, '{255, 255, 255, 255, 255, 255}}, 1'b0, '0},
		'{NO_TUNE, '{1'b0, '{0, 0, 0, 0, 0, 255}}, 1'b0, '0}
	};

	// dut signals; the ones the bench drives are all known from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              restart = 1'b0;
	logic [7:0]        sample_1 = '0;
	logic [7:0]        sample_2 = '0;
	logic [7:0]        sample_3 = '0;
	logic [7:0]        sample_4 = '0;
	logic [7:0]        sample_5 = '0;
	logic [7:0]        sample_6 = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [8:0]        left_drive;
	logic [8:0]        right_drive;
	logic              off_track;
	logic              edge_seen;
	logic signed [8:0] correction;
	logic              wr_en = 1'b0;
	logic [IDX_W-1:0]  wr_index = '0;
	logic [CFG_W-1:0]  wr_data = '0;

	// predictor copy of the registers
	logic [7:0]  cfg_tol    = RST_TOLERANCE;
	logic [6:0]  cfg_pdiv   = RST_P_DIVISOR;
	logic [14:0] cfg_idiv   = RST_I_DIVISOR;
	logic [7:0]  cfg_ddiv   = RST_D_DIVISOR;
	logic [12:0] cfg_center = RST_LINE_CENTER;
	logic [14:0] cfg_ilim   = RST_INTEGRAL_LIMIT;
	logic [7:0]  cfg_min    = RST_MIN_SPEED;
	logic [7:0]  cfg_spd    = RST_SPEED_RANGE;

	// predictor copy of the pid state and edge memory
	int prev_err   = 0;
	int integ_err  = 0;
	bit seen_right = 1'b0;

	steer_t pending_drives [$];
	int     bad_beats    = 0;
	int     idle_pct     = 26;
	int     stall_pct    = 26;
	bit     hold_request = 1'b0;
	int     hold_left    = 0;
	int     track_x      = 2500;

	line_follower_pid_steering u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.sample_1   (sample_1),
		.sample_2   (sample_2),
		.sample_3   (sample_3),
		.sample_4   (sample_4),
		.sample_5   (sample_5),
		.sample_6   (sample_6),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.left_drive (left_drive),
		.right_drive(right_drive),
		.off_track  (off_track),
		.edge_seen  (edge_seen),
		.correction (correction),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// timeout
	initial begin
		#5_000_000;
		$display("FAIL line_follower_pid_steering");
		$finish;
	end

	// a divisor register of zero divides by one
	function automatic int at_least_one(int d);
		return (d == 0) ? 1 : d;
	endfunction

	// drives for one accepted frame; advances the pid state and edge memory
	function automatic steer_t predict_drives(frame_t f);
		steer_t r;
		int     i;
		int     sum;
		int     wsum;
		int     pos;
		int     err;
		int     derr;
		int     cand;
		int     corr;
		int     rng;
		int     half;
		int     lft;
		int     rgt;
		bit     all_low;
		if (f.rst) begin
			prev_err  = 0;
			integ_err = 0;
		end
		sum     = 0;
		wsum    = 0;
		all_low = 1'b1;
		for (i = 0; i < SENSOR_COUNT; i++) begin
			sum  += int'(f.smp[i]);
			wsum += int'(f.smp[i]) * WEIGHT_STEP * i;
			if (f.smp[i] >= cfg_tol)
				all_low = 1'b0;
		end
		// leftmost sensor wins the edge memory
		if (f.smp[0] > EDGE_LEVEL)
			seen_right = 1'b0;
		else if (f.smp[SENSOR_COUNT-1] > EDGE_LEVEL)
			seen_right = 1'b1;
		r.off = all_low || (sum == 0);
		corr  = 0;
		if (r.off) begin
			lft = int'(cfg_min) + (seen_right ? 0 : OFF_BOOST);
			rgt = int'(cfg_min) + (seen_right ? OFF_BOOST : 0);
		end else begin
			pos  = wsum / sum;
			err  = pos - int'(cfg_center);
			derr = err - prev_err;
			// integral add is dropped when it reaches the limit
			cand = integ_err + (err >>> 8);
			if (!(cand >= int'(cfg_ilim) || cand <= -int'(cfg_ilim)))
				integ_err = cand;
			prev_err = err;
			corr = err / at_least_one(int'(cfg_pdiv)) + integ_err / at_least_one(int'(cfg_idiv))
				+ derr / at_least_one(int'(cfg_ddiv));
			rng = int'(cfg_spd);
			if (corr > rng)
				corr = rng;
			else if (corr < -rng)
				corr = -rng;
			half = int'(cfg_min) + rng / 2;
			lft  = half - corr / 2;
			rgt  = half + corr / 2;
		end
		r.l_drv      = 9'(lft);
		r.r_drv      = 9'(rgt);
		r.edge_right = seen_right;
		r.corr       = 9'(corr);
		return r;
	endfunction

	// random frame: mostly a line bump that drifts, some lost-line, empty and raw frames
	function automatic frame_t make_frame();
		frame_t f;
		int     i;
		int     kind;
		int     peak;
		int     spread;
		int     d;
		int     v;
		f.rst = ($urandom_range(99) < 3);
		kind  = $urandom_range(99);
		if (kind < 72) begin
			track_x += int'($urandom_range(700)) - 350;
			if (track_x < 0)
				track_x = 0;
			else if (track_x > 5000)
				track_x = 5000;
			peak   = $urandom_range(60, 255);
			spread = $urandom_range(500, 2200);
			for (i = 0; i < SENSOR_COUNT; i++) begin
				d = i * WEIGHT_STEP - track_x;
				if (d < 0)
					d = -d;
				v = (d < spread) ? peak * (spread - d) / spread : 0;
				v += $urandom_range(15);
				f.smp[i] = (v > 255) ? 8'd255 : 8'(v);
			end
		end else if (kind < 84) begin
			// line lost: every sensor under the threshold
			for (i = 0; i < SENSOR_COUNT; i++)
				f.smp[i] = (cfg_tol == 0) ? 8'd0 : 8'($urandom_range(int'(cfg_tol) - 1));
		end else if (kind < 88) begin
			for (i = 0; i < SENSOR_COUNT; i++)
				f.smp[i] = 8'd0;
		end else begin
			for (i = 0; i < SENSOR_COUNT; i++)
				f.smp[i] = 8'($urandom_range(255));
		end
		return f;
	endfunction

	function automatic tuning_t random_tuning();
		tuning_t t;
		t.tol    = $urandom_range(10, 140);
		t.pdiv   = $urandom_range(127);
		t.idiv   = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 500);
		t.ddiv   = $urandom_range(255);
		t.center = ($urandom_range(4) == 0) ? $urandom_range(8191) : $urandom_range(500, 4500);
		t.ilim   = ($urandom_range(2) == 0) ? $urandom_range(1, 200) : $urandom_range(32767);
		t.vmin   = $urandom_range(255);
		t.spd    = $urandom_range(255);
		return t;
	endfunction

	// offer one beat, hold it until accepted, then queue its drives
	task automatic send_frame(input frame_t f, input bit typed, input steer_t want);
		steer_t exp_drv;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= f.rst;
		sample_1 <= f.smp[0];
		sample_2 <= f.smp[1];
		sample_3 <= f.smp[2];
		sample_4 <= f.smp[3];
		sample_5 <= f.smp[4];
		sample_6 <= f.smp[5];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		exp_drv = predict_drives(f);
		pending_drives.push_back(typed ? want : exp_drv);
	endtask

	// stop offering and wait for every queued result
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_drives.size() != 0);
	endtask

	task automatic set_reg(input logic [IDX_W-1:0] idx, input int val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_W'(val);
		@(posedge clk);
		case (idx)
			REG_TOLERANCE:      cfg_tol    = 8'(val);
			REG_P_DIVISOR:      cfg_pdiv   = 7'(val);
			REG_I_DIVISOR:      cfg_idiv   = 15'(val);
			REG_D_DIVISOR:      cfg_ddiv   = 8'(val);
			REG_LINE_CENTER:    cfg_center = 13'(val);
			REG_INTEGRAL_LIMIT: cfg_ilim   = 15'(val);
			REG_MIN_SPEED:      cfg_min    = 8'(val);
			REG_SPEED_RANGE:    cfg_spd    = 8'(val);
			default: ;
		endcase
	endtask

	// registers change only with the block idle
	task automatic apply_tuning(input tuning_t t);
		drain();
		set_reg(REG_TOLERANCE, t.tol);
		set_reg(REG_P_DIVISOR, t.pdiv);
		set_reg(REG_I_DIVISOR, t.idiv);
		set_reg(REG_D_DIVISOR, t.ddiv);
		set_reg(REG_LINE_CENTER, t.center);
		set_reg(REG_INTEGRAL_LIMIT, t.ilim);
		set_reg(REG_MIN_SPEED, t.vmin);
		set_reg(REG_SPEED_RANGE, t.spd);
		wr_en <= 1'b0;
	endtask

	// receiver stalls, with a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	// compare each result beat with the oldest queued drives
	always @(posedge clk) begin : check_drives
		steer_t got;
		steer_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{left_drive, right_drive, off_track, edge_seen, correction};
			if (pending_drives.size() == 0) begin
				$error("result beat with no expected drives");
				bad_beats++;
			end else begin
				want = pending_drives.pop_front();
				if (got.l_drv !== want.l_drv) begin
					$error("left_drive: expected %0d, got %0d", want.l_drv, got.l_drv);
					bad_beats++;
				end
				if (got.r_drv !== want.r_drv) begin
					$error("right_drive: expected %0d, got %0d", want.r_drv, got.r_drv);
					bad_beats++;
				end
				if (got.off !== want.off) begin
					$error("off_track: expected %0d, got %0d", want.off, got.off);
					bad_beats++;
				end
				if (got.edge_right !== want.edge_right) begin
					$error("edge_seen: expected %0d, got %0d", want.edge_right, got.edge_right);
					bad_beats++;
				end
				if (got.corr !== want.corr) begin
					$error("correction: expected %0d, got %0d",
						$signed(want.corr), $signed(got.corr));
					bad_beats++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		tuning_t t;
		int      k;
		int      ph;
		int      n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (k = 0; k < N_ROWS; k++) begin
			if (script[k].tune != NO_TUNE)
				apply_tuning(tunings[script[k].tune]);
			send_frame(script[k].f, script[k].typed, script[k].want);
		end

		// random phases; the second one runs with no idling on either side
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0:       t = tunings[TUNE_RESET];
				1:       t = tunings[TUNE_MID];
				default: t = random_tuning();
			endcase
			apply_tuning(t);
			idle_pct  = (ph == 1) ? 0 : 26;
			stall_pct = (ph == 1) ? 0 : 26;
			for (n = 0; n < 156; n++) begin
				// receiver holds off while the sender keeps offering
				if (ph == 0 && (n == 40 || n == 110))
					hold_request = 1'b1;
				send_frame(make_frame(), 1'b0, '0);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (bad_beats == 0)
			$display("PASS line_follower_pid_steering");
		else
			$display("FAIL line_follower_pid_steering");
		$finish;
	end

endmodule
